@@ rtl/kwm_pkg.sv @@
// kwm_pkg: shared constants, codes and types of the k-way merge unit
// no dependencies; imported by the interfaces, the top level and the checker

package kwm_pkg;

    localparam int NUM_SOURCES = 16;
    localparam int SRC_W       = 4;
    localparam int CNT_W       = $clog2(NUM_SOURCES + 1);
    localparam int KEY_W       = 63;
    localparam int ACT_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SOURCES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ENABLE = 2'd2;

    localparam logic CMD_PART  = 1'b0;
    localparam logic CMD_MERGE = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_EMIT_PART  = 2'd0,
        ACT_EMIT_MERGE = 2'd1,
        ACT_DROP_MERGE = 2'd2,
        ACT_DONE       = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MS_EMPTY    = 2'd0,
        MS_LIVE     = 2'd1,
        MS_DONE     = 2'd2,
        MS_LIVE_ERR = 2'd3
    } merge_state_t;

endpackage

@@ rtl/kwm_if.sv @@
// kwm_if: valid/ready channels for head items and decision items
// depends on kwm_pkg

interface kwm_head_if
    import kwm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             command;
    logic [SRC_W-1:0] source;
    logic [KEY_W-1:0] key;
    logic             exhausted;

    modport source_mp (output valid, command, source, key, exhausted, input ready);
    modport sink (input valid, command, source, key, exhausted, output ready);
endinterface

interface kwm_result_if
    import kwm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [SRC_W-1:0] chosen_source;
    logic             write_flag;
    logic             order_error;

    modport source (output valid, action, chosen_source, write_flag, order_error, input ready);
    modport sink (input valid, action, chosen_source, write_flag, order_error, output ready);
endinterface

@@ rtl/kway_merge_with_replace_unit.sv @@
// an accepted head item is checked: are all heads in use loaded, and the merge head too
// when merging is on? If not, the unit returns to idle without a decision item; if so,
// it scans the head-key memory (one read port, one key per cycle) and registers a
// decision item, held while the result channel stalls; head items are taken only in idle
// reset: asynchronous, active low; resets live/loaded bits, merge state and config
// head keys live in kwm_ram and are not cleared; depends on kwm_pkg, kwm_if, kwm_ram

module kway_merge_with_replace_unit
    import kwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    kwm_head_if.sink              head_ch,
    kwm_result_if.source          result_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     num_sources_reg;
    logic                 merge_enable_reg;
    logic                 write_enable_reg;

    logic [NUM_SOURCES-1:0] head_live_reg;
    logic [NUM_SOURCES-1:0] head_loaded_reg;
    logic [KEY_W-1:0]       merge_head_reg;
    merge_state_t           merge_state_reg;
    logic [KEY_W-1:0]       last_merge_key_reg;

    logic [CNT_W-1:0]     issue_cnt_reg;
    logic                 cmp_valid_reg;
    logic [SRC_W-1:0]     cmp_idx_reg;
    logic                 found_reg;
    logic [SRC_W-1:0]     best_reg;
    logic [KEY_W-1:0]     best_key_reg;

    logic                 out_valid_reg;
    action_t              action_reg;
    logic [SRC_W-1:0]     chosen_reg;
    logic                 write_flag_reg;
    logic                 order_error_reg;

    logic [CNT_W-1:0]       n_eff;
    logic [NUM_SOURCES-1:0] used_mask;
    logic                   accept;
    logic                   src_ok;
    logic                   ram_we;
    logic                   ram_re;
    logic [KEY_W-1:0]       ram_rdata;
    logic                   all_loaded;
    logic                   issue_more;
    logic                   scan_last;
    logic                   better;
    logic                   merge_live;
    logic                   take_merge;
    logic                   merge_smaller;
    logic                   out_free;

    always_comb
    begin
        priority if (num_sources_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (num_sources_reg > CNT_W'(NUM_SOURCES))
        begin
            n_eff = CNT_W'(NUM_SOURCES);
        end
        else
        begin
            n_eff = num_sources_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            used_mask[i] = CNT_W'(i) < n_eff;
        end
    end

    assign head_ch.ready = (state_reg == ST_IDLE);
    assign accept        = head_ch.valid && head_ch.ready;
    assign src_ok        = {1'b0, head_ch.source} < n_eff;
    assign ram_we        = accept && (head_ch.command == CMD_PART) && src_ok;

    assign all_loaded = ((head_loaded_reg & used_mask) == used_mask)
                        && !(merge_enable_reg && (merge_state_reg == MS_EMPTY));

    assign issue_more = (state_reg == ST_SCAN) && (issue_cnt_reg < n_eff);
    assign ram_re     = issue_more;
    assign scan_last  = cmp_valid_reg && ({1'b0, cmp_idx_reg} == (n_eff - CNT_W'(1)));
    assign better     = cmp_valid_reg && head_live_reg[cmp_idx_reg]
                        && (!found_reg || (ram_rdata < best_key_reg));

    assign merge_live    = merge_enable_reg
                           && ((merge_state_reg == MS_LIVE) || (merge_state_reg == MS_LIVE_ERR));
    assign take_merge    = merge_live && (!found_reg || (merge_head_reg <= best_key_reg));
    assign merge_smaller = !found_reg || (merge_head_reg < best_key_reg);
    assign out_free      = !out_valid_reg || result_ch.ready;

    kwm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (NUM_SOURCES)
    ) u_head_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_ch.source),
        .wdata (head_ch.key),
        .re    (ram_re),
        .raddr (issue_cnt_reg[SRC_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            num_sources_reg    <= CNT_W'(1);
            merge_enable_reg   <= 1'b0;
            write_enable_reg   <= 1'b1;
            head_live_reg      <= '0;
            head_loaded_reg    <= '0;
            merge_head_reg     <= '0;
            merge_state_reg    <= MS_EMPTY;
            last_merge_key_reg <= '0;
            issue_cnt_reg      <= '0;
            cmp_valid_reg      <= 1'b0;
            cmp_idx_reg        <= '0;
            found_reg          <= 1'b0;
            best_reg           <= '0;
            best_key_reg       <= '0;
            out_valid_reg      <= 1'b0;
            action_reg         <= ACT_DONE;
            chosen_reg         <= '0;
            write_flag_reg     <= 1'b0;
            order_error_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_SOURCES:  num_sources_reg  <= cfg_data;
                    CFG_MERGE_ENABLE: merge_enable_reg <= cfg_data[0];
                    CFG_WRITE_ENABLE: write_enable_reg <= cfg_data[0];
                    default:          ;
                endcase
            end

            if ((state_reg == ST_DECIDE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CHECK;
                        if (head_ch.command == CMD_PART)
                        begin
                            if (src_ok)
                            begin
                                head_loaded_reg[head_ch.source] <= 1'b1;
                                head_live_reg[head_ch.source]   <= !head_ch.exhausted;
                            end
                        end
                        else if (merge_enable_reg)
                        begin
                            if (head_ch.exhausted)
                            begin
                                merge_state_reg <= MS_DONE;
                            end
                            else
                            begin
                                merge_state_reg    <= (head_ch.key < last_merge_key_reg)
                                                      ? MS_LIVE_ERR : MS_LIVE;
                                merge_head_reg     <= head_ch.key;
                                last_merge_key_reg <= head_ch.key;
                            end
                        end
                    end
                end
                ST_CHECK:
                begin
                    issue_cnt_reg <= '0;
                    cmp_valid_reg <= 1'b0;
                    found_reg     <= 1'b0;
                    best_reg      <= '0;
                    state_reg     <= all_loaded ? ST_SCAN : ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (issue_more)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                    end
                    cmp_valid_reg <= issue_more;
                    cmp_idx_reg   <= issue_cnt_reg[SRC_W-1:0];
                    if (better)
                    begin
                        found_reg    <= 1'b1;
                        best_reg     <= cmp_idx_reg;
                        best_key_reg <= ram_rdata;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                        priority if (take_merge)
                        begin
                            action_reg      <= merge_smaller ? ACT_EMIT_MERGE : ACT_DROP_MERGE;
                            chosen_reg      <= '0;
                            write_flag_reg  <= merge_smaller && write_enable_reg;
                            order_error_reg <= (merge_state_reg == MS_LIVE_ERR);
                            merge_state_reg <= MS_EMPTY;
                        end
                        else if (found_reg)
                        begin
                            action_reg                <= ACT_EMIT_PART;
                            chosen_reg                <= best_reg;
                            write_flag_reg            <= write_enable_reg;
                            order_error_reg           <= 1'b0;
                            head_loaded_reg[best_reg] <= 1'b0;
                        end
                        else
                        begin
                            action_reg      <= ACT_DONE;
                            chosen_reg      <= '0;
                            write_flag_reg  <= 1'b0;
                            order_error_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.action        = action_reg;
    assign result_ch.chosen_source = chosen_reg;
    assign result_ch.write_flag    = write_flag_reg;
    assign result_ch.order_error   = order_error_reg;

endmodule

@@ rtl/kwm_ram.sv @@
// kwm_ram: generic single-write, single-read memory with registered read data
// no dependencies

module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kwm_checker.sv @@
// kwm_checker: port-level assertions on the decision channel of the merge unit
// depends on kwm_pkg; bound to kway_merge_with_replace_unit

module kwm_checker
    import kwm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [ACT_W-1:0] action,
    input logic [SRC_W-1:0] chosen_source,
    input logic             write_flag,
    input logic             order_error
);

    // a stalled item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_EMIT_PART) |-> (chosen_source == '0))
        else $error("chosen_source set for a non-partition action");

    a_write_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_flag |-> (action == ACT_EMIT_PART) || (action == ACT_EMIT_MERGE))
        else $error("write_flag set for drop or done");

    a_order_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && order_error |-> (action == ACT_EMIT_MERGE) || (action == ACT_DROP_MERGE))
        else $error("order_error set for a non-merge action");

endmodule

bind kway_merge_with_replace_unit kwm_checker u_kwm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .action        (result_ch.action),
    .chosen_source (result_ch.chosen_source),
    .write_flag    (result_ch.write_flag),
    .order_error   (result_ch.order_error)
);
